// ===== hw/rtl/c3zb_pkg.sv =====
`default_nettype none

package c3zb_pkg;

    localparam int PIXEL_W    = 16;
    localparam int COEF_W     = 5;
    localparam int VALUE_W    = 24;
    localparam int PROD_W     = PIXEL_W + COEF_W;
    localparam int DIM_CFG_W  = 9;
    localparam int KROW_W     = 3 * COEF_W;
    localparam int CFG_DATA_W = KROW_W;
    localparam int CFG_IDX_W  = 2;
    localparam int MIN_SIDE   = 3;
    localparam int DIM_RESET  = 256;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_DIM  = 2'd0,
        REG_KERNEL_TOP = 2'd1,
        REG_KERNEL_MID = 2'd2,
        REG_KERNEL_BOT = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic signed [PIXEL_W-1:0] pixel;
        logic                      filler;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last_of_frame;
    } t_out_item;

    // per-item position flags
    typedef struct packed {
        logic has_result;
        logic interior;
        logic last;
        logic is_pixel;
    } t_pos_info;

    // coefficient k of a kernel row: k=0 left, 1 center, 2 right
    function automatic logic signed [COEF_W-1:0] coef_at(input logic [KROW_W-1:0] row,
                                                         input logic [1:0] k);
        logic [COEF_W-1:0] c;
        case (k)
            2'd0:    c = row[COEF_W-1:0];
            2'd1:    c = row[2*COEF_W-1:COEF_W];
            default: c = row[3*COEF_W-1:2*COEF_W];
        endcase
        return signed'(c);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/conv3x3_zero_border.sv =====
// conv3x3_zero_border: streaming 3x3 convolution with a signed programmable kernel.
// Input channel (i_in_valid / o_in_ready, payload i_in): one pixel per transfer in
// raster order. After the side*side pixels of a frame send side+1 filler transfers;
// the transfer after those starts the next frame. Filler inside the frame counts as
// a zero pixel; anything in the drain phase is taken as filler.
// Output channel (o_out_valid / i_out_ready, payload o_out): one result per transfer
// from the (side+2)th input on, in raster order; the outer ring of the image is zero
// and last_of_frame marks the final pixel.
// Pipeline: stage 1 (line memory read), window, products, row sums, output register.
// Throughput: one transfer per cycle unless a result waits in the output register;
// the line memory is read on acceptance and written back as the item leaves stage 1;
// a column is touched again at least three items later, so no forwarding is needed.
// Stall: a single pipeline enable (output register empty or taken) holds every stage;
// o_in_ready drops only while a result sits unaccepted in the output register.
// Config (i_cfg_we/i_cfg_idx/i_cfg_wdata): write only while idle. Writing image_dim
// restarts the frame position; the side is clamped to [3, MAX_DIM].
// Reset: position, valid bits and config registers clear (side = 256 clamped to
// MAX_DIM, kernel zero). No memory clearing pass: stale line data reaches only
// border outputs, which are forced to zero.
`default_nettype none

module conv3x3_zero_border #(
    parameter int MAX_DIM = 256
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [c3zb_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [c3zb_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire c3zb_pkg::t_in_item                   i_in,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output c3zb_pkg::t_out_item                       o_out
);

    localparam int A_W   = $clog2(MAX_DIM);
    localparam int D_W   = $clog2(MAX_DIM + 1);
    localparam int EXT_W = (D_W > c3zb_pkg::DIM_CFG_W) ? D_W : c3zb_pkg::DIM_CFG_W;
    localparam int PW    = c3zb_pkg::PIXEL_W;
    localparam int SIDE_RESET = (c3zb_pkg::DIM_RESET > MAX_DIM) ? MAX_DIM
                                                                 : c3zb_pkg::DIM_RESET;

    // config registers
    logic [D_W-1:0]              r_side, n_side;
    logic [c3zb_pkg::KROW_W-1:0] r_krow_top, r_krow_mid, r_krow_bot;
    logic [EXT_W-1:0]            cfg_dim;
    logic                        restart;

    // pipeline control
    logic                        adv;
    logic                        accept;
    logic [A_W-1:0]              col;
    c3zb_pkg::t_pos_info         info;
    logic signed [PW-1:0]        px;

    // stage 1: line memory data arrives
    logic                        r_s1_valid;
    c3zb_pkg::t_pos_info         r_s1_info;
    logic [A_W-1:0]              r_s1_col;
    logic signed [PW-1:0]        r_s1_px;
    logic [2*PW-1:0]             rd_data;
    logic                        mac_valid;

    // clamp side on write
    assign cfg_dim = EXT_W'(i_cfg_wdata[c3zb_pkg::DIM_CFG_W-1:0]);

    always_comb begin
        if (cfg_dim < EXT_W'(c3zb_pkg::MIN_SIDE)) begin
            n_side = D_W'(c3zb_pkg::MIN_SIDE);
        end else if (cfg_dim > EXT_W'(MAX_DIM)) begin
            n_side = D_W'(MAX_DIM);
        end else begin
            n_side = D_W'(cfg_dim);
        end
    end

    assign restart = i_cfg_we && (c3zb_pkg::t_cfg_reg'(i_cfg_idx) == c3zb_pkg::REG_IMAGE_DIM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side     <= D_W'(SIDE_RESET);
            r_krow_top <= '0;
            r_krow_mid <= '0;
            r_krow_bot <= '0;
        end else if (i_cfg_we) begin
            unique case (c3zb_pkg::t_cfg_reg'(i_cfg_idx))
                c3zb_pkg::REG_IMAGE_DIM:  r_side     <= n_side;
                c3zb_pkg::REG_KERNEL_TOP: r_krow_top <= i_cfg_wdata;
                c3zb_pkg::REG_KERNEL_MID: r_krow_mid <= i_cfg_wdata;
                c3zb_pkg::REG_KERNEL_BOT: r_krow_bot <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // whole pipeline moves unless a result waits in the output register
    assign adv        = !o_out_valid || i_out_ready;
    assign o_in_ready = adv;
    assign accept     = i_in_valid && adv;

    c3zb_pos #(
        .MAX_DIM (MAX_DIM)
    ) u_pos (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_side    (r_side),
        .i_restart (restart),
        .i_adv     (accept),
        .o_col     (col),
        .o_info    (info)
    );

    assign px = (info.is_pixel && !i_in.filler) ? i_in.pixel : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_info <= info;
            r_s1_col  <= col;
            r_s1_px   <= px;
        end
    end

    // read on acceptance, write {above, current} back as the item leaves stage 1
    c3zb_line_mem #(
        .MAX_DIM (MAX_DIM)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (col),
        .o_rd_data (rd_data),
        .i_wr_en   (adv && r_s1_valid),
        .i_wr_addr (r_s1_col),
        .i_wr_data ({rd_data[PW-1:0], r_s1_px})
    );

    c3zb_mac u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_s1_valid (r_s1_valid),
        .i_s1_info  (r_s1_info),
        .i_up2      (signed'(rd_data[2*PW-1:PW])),
        .i_up1      (signed'(rd_data[PW-1:0])),
        .i_px       (r_s1_px),
        .i_krow_top (r_krow_top),
        .i_krow_mid (r_krow_mid),
        .i_krow_bot (r_krow_bot),
        .o_valid    (mac_valid),
        .o_item     (o_out)
    );

    assign o_out_valid = mac_valid;

`ifndef SYNTH
    a_last_is_border: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.last_of_frame |-> (o_out.value == '0))
        else $error("last pixel of frame not zero");
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && accept |=> r_s1_valid)
        else $error("accepted item lost before line memory stage");
    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && r_s1_valid && !adv |=> r_s1_valid && $stable(r_s1_col))
        else $error("stage 1 item moved during stall");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/c3zb_line_mem.sv =====
`default_nettype none

// Two line stores packed side by side: {row above-above, row above} per column.
module c3zb_line_mem #(
    parameter int MAX_DIM = 256
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rd_en,
    input  wire logic [$clog2(MAX_DIM)-1:0]         i_rd_addr,
    output logic      [2*c3zb_pkg::PIXEL_W-1:0]     o_rd_data,
    input  wire logic                               i_wr_en,
    input  wire logic [$clog2(MAX_DIM)-1:0]         i_wr_addr,
    input  wire logic [2*c3zb_pkg::PIXEL_W-1:0]     i_wr_data
);

    logic [2*c3zb_pkg::PIXEL_W-1:0] r_mem [MAX_DIM];
    logic [2*c3zb_pkg::PIXEL_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== hw/rtl/c3zb_pos.sv =====
`default_nettype none

// Row/column position within the frame, including the drain row.
module c3zb_pos #(
    parameter int MAX_DIM = 256
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic [$clog2(MAX_DIM+1)-1:0]     i_side,
    input  wire logic                             i_restart,
    input  wire logic                             i_adv,
    output logic      [$clog2(MAX_DIM)-1:0]       o_col,
    output c3zb_pkg::t_pos_info                   o_info
);

    localparam int A_W = $clog2(MAX_DIM);
    localparam int D_W = $clog2(MAX_DIM + 1);
    localparam int R_W = $clog2(MAX_DIM + 2);

    logic [A_W-1:0] r_col, n_col;
    logic [R_W-1:0] r_row, n_row;
    logic           at_drain_end;
    logic           at_row_end;

    assign at_drain_end = (r_row == R_W'(i_side) + R_W'(1));
    assign at_row_end   = (D_W'(r_col) == i_side - D_W'(1));

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_restart) begin
            n_col = '0;
            n_row = '0;
        end else if (i_adv) begin
            if (at_drain_end) begin
                n_col = '0;
                n_row = '0;
            end else if (at_row_end) begin
                n_col = '0;
                n_row = r_row + R_W'(1);
            end else begin
                n_col = r_col + A_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // first result comes with the item one row plus one pixel in
    always_comb begin
        o_info.has_result = !((r_row == R_W'(0)) || ((r_row == R_W'(1)) && (r_col == A_W'(0))));
        o_info.interior   = (r_col >= A_W'(2)) && (r_row >= R_W'(2)) && (r_row < R_W'(i_side));
        o_info.last       = at_drain_end;
        o_info.is_pixel   = (r_row < R_W'(i_side));
    end

    assign o_col = r_col;

`ifndef SYNTH
    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        D_W'(r_col) < i_side)
        else $error("column beyond side");
    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= R_W'(i_side) + R_W'(1))
        else $error("row beyond drain row");
    a_drain_end_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        at_drain_end |-> (r_col == A_W'(0)))
        else $error("drain end item not at column zero");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/c3zb_mac.sv =====
`default_nettype none

// 3x3 window, nine products, row sums, final sum and output register.
module c3zb_mac (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_adv,
    input  wire logic                                  i_s1_valid,
    input  wire c3zb_pkg::t_pos_info                   i_s1_info,
    input  wire logic signed [c3zb_pkg::PIXEL_W-1:0]   i_up2,
    input  wire logic signed [c3zb_pkg::PIXEL_W-1:0]   i_up1,
    input  wire logic signed [c3zb_pkg::PIXEL_W-1:0]   i_px,
    input  wire logic        [c3zb_pkg::KROW_W-1:0]    i_krow_top,
    input  wire logic        [c3zb_pkg::KROW_W-1:0]    i_krow_mid,
    input  wire logic        [c3zb_pkg::KROW_W-1:0]    i_krow_bot,
    output logic                                       o_valid,
    output c3zb_pkg::t_out_item                        o_item
);

    localparam int PW = c3zb_pkg::PIXEL_W;
    localparam int QW = c3zb_pkg::PROD_W;
    localparam int VW = c3zb_pkg::VALUE_W;

    logic signed [PW-1:0] r_win [3][3];
    logic signed [QW-1:0] r_prod [3][3];
    logic signed [VW-1:0] r_rsum [3];
    logic signed [VW-1:0] ext [3][3];
    logic [c3zb_pkg::KROW_W-1:0] krow [3];

    logic r_s2_valid, r_s2_int, r_s2_last;
    logic r_s3_valid, r_s3_int, r_s3_last;
    logic r_s4_valid, r_s4_int, r_s4_last;
    logic r_out_valid;
    c3zb_pkg::t_out_item r_out;

    assign krow[0] = i_krow_top;
    assign krow[1] = i_krow_mid;
    assign krow[2] = i_krow_bot;

    // window shift: new column enters on the right
    always_ff @(posedge i_clk) begin
        if (i_adv && i_s1_valid) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= i_up2;
            r_win[1][2] <= i_up1;
            r_win[2][2] <= i_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_prod[r][c] <= r_win[r][c] * c3zb_pkg::coef_at(krow[r], 2'(c));
                end
            end
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                ext[r][c] = {{(VW-QW){r_prod[r][c][QW-1]}}, r_prod[r][c]};
            end
        end
    end

    // sums wrap at the output width
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int r = 0; r < 3; r++) begin
                r_rsum[r] <= ext[r][0] + ext[r][1] + ext[r][2];
            end
            r_out.value         <= r_s4_int ? (r_rsum[0] + r_rsum[1] + r_rsum[2]) : '0;
            r_out.last_of_frame <= r_s4_last;
            r_s2_int  <= i_s1_info.interior;
            r_s2_last <= i_s1_info.last;
            r_s3_int  <= r_s2_int;
            r_s3_last <= r_s2_last;
            r_s4_int  <= r_s3_int;
            r_s4_last <= r_s3_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_adv) begin
            r_s2_valid  <= i_s1_valid && i_s1_info.has_result;
            r_s3_valid  <= r_s2_valid;
            r_s4_valid  <= r_s3_valid;
            r_out_valid <= r_s4_valid;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

`default_nettype wire

// ===== verif/tb_conv3x3_zero_border.sv =====
`timescale 1ns / 100ps

module tb_conv3x3_zero_border;

    localparam int MAX_SIDE      = 256;
    localparam int LATENCY       = 4;
    // margin after the last expected result: covers items still in flight that
    // cause no result (first row plus one pixel of a frame)
    localparam int SETTLE_CYCLES = 2 * LATENCY + 2;
    localparam int STALL_LIMIT   = 1000;
    localparam int RANDOM_ITEMS  = 1000;

    // kernel rows with every coefficient at one extreme (5-bit signed)
    localparam logic [c3zb_pkg::KROW_W-1:0] KROW_ALL_MIN = 15'h4210;  // -16, -16, -16
    localparam logic [c3zb_pkg::KROW_W-1:0] KROW_ALL_MAX = 15'h3def;  // +15, +15, +15

    // ------------------------------------------------------------------
    // DUT hookup; every input has a known value from time zero
    // ------------------------------------------------------------------
    logic                            i_clk;
    logic                            i_rst_n     = 1'b0;
    logic                            i_cfg_we    = 1'b0;
    logic [c3zb_pkg::CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [c3zb_pkg::CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                            i_in_valid  = 1'b0;
    logic                            o_in_ready;
    c3zb_pkg::t_in_item              i_in        = '0;
    logic                            o_out_valid;
    logic                            i_out_ready = 1'b0;
    c3zb_pkg::t_out_item             o_out;

    conv3x3_zero_border #(
        .MAX_DIM(MAX_SIDE)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor state: own copy of config, line stores, window, position
    // ------------------------------------------------------------------
    logic [c3zb_pkg::DIM_CFG_W-1:0]      cfg_dim;
    logic [c3zb_pkg::KROW_W-1:0]         kernel_rows [3];         // 0 top, 1 mid, 2 bottom
    logic signed [c3zb_pkg::PIXEL_W-1:0] line_up2    [MAX_SIDE];  // two rows above
    logic signed [c3zb_pkg::PIXEL_W-1:0] line_up1    [MAX_SIDE];  // one row above
    logic signed [c3zb_pkg::PIXEL_W-1:0] win_px      [3][3];      // [row][col], col 2 newest
    int unsigned                         frame_pos;

    c3zb_pkg::t_out_item conv_expected [$];
    int unsigned err_count    = 0;
    int unsigned results_seen = 0;
    int unsigned items_in     = 0;
    int unsigned src_gap_pct  = 0;  // chance of an idle burst before a transfer
    bit          calm         = 1'b1;

    // side as the block uses it: clamped to [MIN_SIDE, MAX_SIDE]
    function automatic int unsigned eff_side();
        if (cfg_dim < c3zb_pkg::MIN_SIDE) return c3zb_pkg::MIN_SIDE;
        if (cfg_dim > MAX_SIDE) return MAX_SIDE;
        return int'(cfg_dim);
    endfunction

    // advance by one accepted item; returns 1 when that item produces a result
    function automatic bit conv_predict(input c3zb_pkg::t_in_item it,
                                        output c3zb_pkg::t_out_item res);
        int unsigned                         side, area, col, n, p, pr, pc;
        logic signed [c3zb_pkg::PIXEL_W-1:0] px, up2, up1;
        longint                              acc;
        side = eff_side();
        area = side * side;
        n    = frame_pos;
        col  = n % side;
        // role follows position only: filler inside the frame is a zero pixel,
        // anything in the drain phase is a drain item
        px   = (n < area && !it.filler) ? it.pixel : '0;
        up2  = line_up2[col];
        up1  = line_up1[col];
        line_up2[col] = up1;
        line_up1[col] = px;
        for (int r = 0; r < 3; r++) begin
            win_px[r][0] = win_px[r][1];
            win_px[r][1] = win_px[r][2];
        end
        win_px[0][2] = up2;
        win_px[1][2] = up1;
        win_px[2][2] = px;
        frame_pos = (n >= area + side) ? 0 : n + 1;
        res = '0;
        if (n < side + 1) return 1'b0;
        // output pixel p trails the input by one row plus one pixel
        p   = n - side - 1;
        pr  = p / side;
        pc  = p % side;
        acc = 0;
        if (pr != 0 && pc != 0 && pr != side - 1 && pc != side - 1) begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    acc += longint'($signed(
                               kernel_rows[r][c*c3zb_pkg::COEF_W +: c3zb_pkg::COEF_W]))
                         * longint'(win_px[r][c]);
        end
        res.value         = acc[c3zb_pkg::VALUE_W-1:0];
        res.last_of_frame = (p == area - 1);
        return 1'b1;
    endfunction

    task automatic flag_error(input string msg);
        err_count++;
        $display("%0t ERROR: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic c3zb_pkg::t_in_item make_item(input int unsigned filler_pct);
        c3zb_pkg::t_in_item it;
        case ($urandom_range(0, 9))
            0:       it.pixel = 16'sh8000;
            1:       it.pixel = 16'sh7fff;
            2:       it.pixel = c3zb_pkg::PIXEL_W'($urandom_range(0, 8) - 4);
            default: it.pixel = c3zb_pkg::PIXEL_W'($urandom);
        endcase
        it.filler = ($urandom_range(0, 99) < filler_pct);
        return it;
    endfunction

    function automatic logic [c3zb_pkg::KROW_W-1:0] rand_krow();
        case ($urandom_range(0, 7))
            0:       return KROW_ALL_MIN;
            1:       return KROW_ALL_MAX;
            2:       return '0;
            default: return c3zb_pkg::KROW_W'($urandom);
        endcase
    endfunction

    // one input transfer; the expectation is the typed one if given, else predicted
    task automatic push_pixel(input c3zb_pkg::t_in_item it, input bit typed = 1'b0,
                              input c3zb_pkg::t_out_item typed_want = '0);
        c3zb_pkg::t_out_item res;
        bit                  has;
        if (!calm && $urandom_range(0, 99) < src_gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        has = conv_predict(it, res);
        if (typed)
            conv_expected.push_back(typed_want);
        else if (has)
            conv_expected.push_back(res);
        items_in++;
    endtask

    // all expected results out, then let items that cause none clear the pipe
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (conv_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input c3zb_pkg::t_cfg_reg idx,
                             input logic [c3zb_pkg::CFG_DATA_W-1:0] val);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            c3zb_pkg::REG_IMAGE_DIM: begin
                // side write restarts the frame position; stores are kept
                cfg_dim   = val[c3zb_pkg::DIM_CFG_W-1:0];
                frame_pos = 0;
            end
            c3zb_pkg::REG_KERNEL_TOP: kernel_rows[0] = val[c3zb_pkg::KROW_W-1:0];
            c3zb_pkg::REG_KERNEL_MID: kernel_rows[1] = val[c3zb_pkg::KROW_W-1:0];
            default:                  kernel_rows[2] = val[c3zb_pkg::KROW_W-1:0];
        endcase
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Directed table
    //   ROW_REG   : register write (idx, wdata)
    //   ROW_ITEM  : input transfer checked against the predictor
    //   ROW_TYPED : input transfer with its result typed in (value, last)
    // idx is a don't-care on item rows.
    // ------------------------------------------------------------------
    typedef enum logic [1:0] {ROW_REG, ROW_ITEM, ROW_TYPED} t_row_kind;

    typedef struct packed {
        t_row_kind                       kind;
        c3zb_pkg::t_cfg_reg              idx;
        logic [c3zb_pkg::CFG_DATA_W-1:0] wdata;
        logic [c3zb_pkg::PIXEL_W-1:0]    pixel;
        logic                            filler;
        logic [c3zb_pkg::VALUE_W-1:0]    value;
        logic                            last;
    } t_plan_row;

    localparam int PLAN_ROWS = 34;

    localparam t_plan_row PLAN [PLAN_ROWS] = '{
        // frame A: side 3, kernel mid row = left 1, center 1 -> out(4) = px3 + px4
        '{ROW_REG,   c3zb_pkg::REG_IMAGE_DIM,  15'd3,    16'h0000, 1'b0, 24'h000000, 1'b0},
        '{ROW_REG,   c3zb_pkg::REG_KERNEL_TOP, 15'h0000, 16'h0000, 1'b0, 24'h000000, 1'b0},
        '{ROW_REG,   c3zb_pkg::REG_KERNEL_MID, 15'h0021, 16'h0000, 1'b0, 24'h000000, 1'b0},
        '{ROW_REG,   c3zb_pkg::REG_KERNEL_BOT, 15'h0000, 16'h0000, 1'b0, 24'h000000, 1'b0},
        '{ROW_ITEM,  c3zb_pkg::REG_IMAGE_DIM,  15'h0000, 16'h8000, 1'b0, 24'h000000, 1'b0},
        '{ROW_ITEM,  c3zb_pkg::REG_IMAGE_DIM,  15'h0000, 16'h7fff, 1'b0, 24'h000000, 1'b0},
        '{ROW_ITEM,  c3zb_pkg::REG_IMAGE_DIM,  15'h0000, 16'h5555, 1'b0, 24'h000000, 1'b0},
        // filler inside the frame: counts as zero whatever its pixel field
        '{ROW_ITEM,  c3zb_pkg::REG_IMAGE_DIM,  15'h0000, 16'h1234, 1'b1, 24'h000000, 1'b0},
        '{ROW_TYPED, c3zb_pkg::REG_IMAGE_DIM,  15'h0000, 16'h7fff, 1'b0, 24'h000000, 1'b0},
        '{ROW_TYPED, c3zb_pkg::REG_IMAGE_DIM,  15'h0000, 16'haaaa, 1'b0, 24'h000000, 1'b0},
        '{ROW_TYPED, c3zb_pkg::REG_IMAGE_DIM,  15'h0000, 16'hffff, 1'b0, 24'h000000, 1'b0},
        '{ROW_TYPED, c3zb_pkg::REG_IMAGE_DIM,  15'h0000, 16'h0001, 1'b0, 24'h000000, 1'b0},
        '{ROW_TYPED, c3zb_pkg::REG_IMAGE_DIM,  15'h0000, 16'h8000, 1'b0, 24'h007fff, 1'b0},
        '{ROW_TYPED, c3zb_pkg::REG_IMAGE_DIM,  15'h0000, 16'h0000, 1'b1, 24'h000000, 1'b0},
        // drain item with filler low: pixel ignored
        '{ROW_TYPED, c3zb_pkg::REG_IMAGE_DIM,  15'h0000, 16'h7fff, 1'b0, 24'h000000, 1'b0},
        '{ROW_TYPED, c3zb_pkg::REG_IMAGE_DIM,  15'h0000, 16'h0000, 1'b1, 24'h000000, 1'b0},
        '{ROW_TYPED, c3zb_pkg::REG_IMAGE_DIM,  15'h0000, 16'h0000, 1'b1, 24'h000000, 1'b1},
        // frame B: side 0 clamps to 3, all coefs -16, all pixels -32768:
        // center sum 9 * 524288, border of stale data forced to zero
        '{ROW_REG,   c3zb_pkg::REG_IMAGE_DIM,  15'd0,    16'h0000, 1'b0, 24'h000000, 1'b0},
        '{ROW_REG,   c3zb_pkg::REG_KERNEL_TOP, 15'h4210, 16'h0000, 1'b0, 24'h000000, 1'b0},
        '{ROW_REG,   c3zb_pkg::REG_KERNEL_MID, 15'h4210, 16'h0000, 1'b0, 24'h000000, 1'b0},
        '{ROW_REG,   c3zb_pkg::REG_KERNEL_BOT, 15'h4210, 16'h0000, 1'b0, 24'h000000, 1'b0},
        '{ROW_ITEM,  c3zb_pkg::REG_IMAGE_DIM,  15'h0000, 16'h8000, 1'b0, 24'h000000, 1'b0},
        '{ROW_ITEM,  c3zb_pkg::REG_IMAGE_DIM,  15'h0000, 16'h8000, 1'b0, 24'h000000, 1'b0},
        '{ROW_ITEM,  c3zb_pkg::REG_IMAGE_DIM,  15'h0000, 16'h8000, 1'b0, 24'h000000, 1'b0},
        '{ROW_ITEM,  c3zb_pkg::REG_IMAGE_DIM,  15'h0000, 16'h8000, 1'b0, 24'h000000, 1'b0},
        '{ROW_TYPED, c3zb_pkg::REG_IMAGE_DIM,  15'h0000, 16'h8000, 1'b0, 24'h000000, 1'b0},
        '{ROW_TYPED, c3zb_pkg::REG_IMAGE_DIM,  15'h0000, 16'h8000, 1'b0, 24'h000000, 1'b0},
        '{ROW_TYPED, c3zb_pkg::REG_IMAGE_DIM,  15'h0000, 16'h8000, 1'b0, 24'h000000, 1'b0},
        '{ROW_TYPED, c3zb_pkg::REG_IMAGE_DIM,  15'h0000, 16'h8000, 1'b0, 24'h000000, 1'b0},
        '{ROW_TYPED, c3zb_pkg::REG_IMAGE_DIM,  15'h0000, 16'h8000, 1'b0, 24'h480000, 1'b0},
        '{ROW_TYPED, c3zb_pkg::REG_IMAGE_DIM,  15'h0000, 16'h0000, 1'b1, 24'h000000, 1'b0},
        '{ROW_TYPED, c3zb_pkg::REG_IMAGE_DIM,  15'h0000, 16'h0000, 1'b1, 24'h000000, 1'b0},
        '{ROW_TYPED, c3zb_pkg::REG_IMAGE_DIM,  15'h0000, 16'h0000, 1'b1, 24'h000000, 1'b0},
        '{ROW_TYPED, c3zb_pkg::REG_IMAGE_DIM,  15'h0000, 16'h0000, 1'b1, 24'h000000, 1'b1}
    };

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_plan_row                      row;
        int unsigned                    phase, side, rand_base;
        logic [c3zb_pkg::DIM_CFG_W-1:0] dim_w;
        bit                             big, broke;

        // predictor reset state
        cfg_dim   = c3zb_pkg::DIM_CFG_W'(c3zb_pkg::DIM_RESET);
        frame_pos = 0;
        for (int k = 0; k < 3; k++) kernel_rows[k] = '0;
        for (int c = 0; c < MAX_SIDE; c++) begin
            line_up2[c] = '0;
            line_up1[c] = '0;
        end
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++) win_px[r][c] = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, no idling
        for (int i = 0; i < PLAN_ROWS; i++) begin
            row = PLAN[i];
            case (row.kind)
                ROW_REG:  write_reg(row.idx, row.wdata);
                ROW_ITEM: push_pixel(c3zb_pkg::t_in_item'({row.pixel, row.filler}));
                default: begin
                    push_pixel(c3zb_pkg::t_in_item'({row.pixel, row.filler}), 1'b1,
                               c3zb_pkg::t_out_item'({row.value, row.last}));
                end
            endcase
        end

        // random part: phases of config plus mostly well-formed frames
        rand_base = items_in;
        phase     = 0;
        broke     = 1'b1;
        while (items_in - rand_base < RANDOM_ITEMS) begin
            // last stretch runs with both sides at full rate
            calm        = (items_in - rand_base) > RANDOM_ITEMS * 4 / 5;
            src_gap_pct = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(5, 30);
            // one phase at the largest side, fed only far enough for interior rows
            big = (phase == 2);
            if (big) begin
                dim_w = c3zb_pkg::DIM_CFG_W'($urandom_range(MAX_SIDE, 511));
            end else begin
                case ($urandom_range(0, 9))
                    0: dim_w = c3zb_pkg::DIM_CFG_W'($urandom_range(0, c3zb_pkg::MIN_SIDE - 1));
                    1: dim_w = c3zb_pkg::DIM_CFG_W'($urandom_range(9, 16));
                    default: begin
                        dim_w = c3zb_pkg::DIM_CFG_W'($urandom_range(c3zb_pkg::MIN_SIDE, 8));
                    end
                endcase
            end
            // side write after a broken sequence realigns to a fresh frame
            if (big || broke || $urandom_range(0, 4) != 0)
                write_reg(c3zb_pkg::REG_IMAGE_DIM, c3zb_pkg::CFG_DATA_W'(dim_w));
            if (phase == 0 || $urandom_range(0, 2) != 0)
                write_reg(c3zb_pkg::REG_KERNEL_TOP, rand_krow());
            if (phase == 0 || $urandom_range(0, 2) != 0)
                write_reg(c3zb_pkg::REG_KERNEL_MID, rand_krow());
            if (phase == 0 || $urandom_range(0, 2) != 0)
                write_reg(c3zb_pkg::REG_KERNEL_BOT, rand_krow());

            side  = eff_side();
            broke = 1'b0;
            if (big) begin
                repeat (2 * side + 8 + $urandom_range(0, 40)) push_pixel(make_item(3));
                broke = 1'b1;
            end else begin
                for (int f = $urandom_range(1, 3); f > 0; f--) begin
                    if ($urandom_range(0, 6) == 0) begin
                        // broken: cut short, roles mixed at random
                        repeat ($urandom_range(1, side * side + side)) push_pixel(make_item(50));
                        broke = 1'b1;
                        break;
                    end
                    repeat (side * side) push_pixel(make_item(3));
                    repeat (side + 1) push_pixel(make_item(90));
                end
            end
            phase++;
        end

        calm = 1'b1;
        wait_idle();
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // Output side: ready in random stall bursts, with long ready stretches
    // ------------------------------------------------------------------
    initial begin : sink_pace
        int unsigned span;
        forever begin
            @(posedge i_clk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                span = $urandom_range(1, 19);
            end else begin
                i_out_ready <= 1'b1;
                span = $urandom_range(1, 24);
            end
            repeat (span - 1) @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------
    // Result check: each output transfer against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        c3zb_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (conv_expected.size() == 0) begin
                flag_error($sformatf("unexpected result #%0d value=%0d last=%0b",
                                     results_seen, o_out.value, o_out.last_of_frame));
            end else begin
                want = conv_expected.pop_front();
                if (o_out.value !== want.value)
                    flag_error($sformatf("result #%0d value got %0d expected %0d",
                                         results_seen, o_out.value, want.value));
                if (o_out.last_of_frame !== want.last_of_frame)
                    flag_error($sformatf("result #%0d last_of_frame got %0b expected %0b",
                                         results_seen, o_out.last_of_frame,
                                         want.last_of_frame));
            end
            results_seen++;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too many cycles without any transfer on either side
    // ------------------------------------------------------------------
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== conv3x3_zero_border.f =====
hw/rtl/c3zb_pkg.sv
hw/rtl/c3zb_line_mem.sv
hw/rtl/c3zb_pos.sv
hw/rtl/c3zb_mac.sv
hw/rtl/conv3x3_zero_border.sv
verif/tb_conv3x3_zero_border.sv
